// ===== rtl/hbf_pkg.sv =====
package hbf_pkg;

   // Field and datapath widths
   localparam int POS_W      = 32;
   localparam int BOX_W      = 31;
   localparam int OUT_W      = 48;
   localparam int MAG_W      = 47;
   localparam int R2_W       = 64;
   localparam int ROOT_W     = 32;
   localparam int QUO_W      = 48;
   localparam int WIDE_W     = 80;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Iterative unit depths: one result bit per stage
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = QUO_W;

   localparam int NUM_TYPES_DEF = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_BASE = 3'd3;

   // Reset values
   localparam logic [BOX_W-1:0]        BOX_RST = 31'd655360;
   localparam logic signed [POS_W-1:0] K_RST   = 32'sd0;
   localparam logic signed [POS_W-1:0] R0_RST  = 32'sd65536;

   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // Data that rides along with a bond through the pipeline
   typedef struct packed {
      logic signed [POS_W-1:0] dx;
      logic signed [POS_W-1:0] dy;
      logic signed [POS_W-1:0] dz;
      logic signed [POS_W-1:0] k;
      logic signed [POS_W-1:0] r0;
      logic signed [33:0]      dr;
      logic                    zero;
   } side_type;

   // Clamp a shifted magnitude to the largest 47 bit value
   function automatic logic [MAG_W-1:0] sat_mag(input logic [WIDE_W-1:0] v);
      return (|v[WIDE_W-1:MAG_W]) ? MAG_MAX : v[MAG_W-1:0];
   endfunction

   // Magnitude of a 32 bit signed value
   function automatic logic [POS_W-1:0] abs32(input logic signed [POS_W-1:0] v);
      return v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
   endfunction

   // Displacement with one minimum-image wrap, clamped to 32 bits
   function automatic logic signed [POS_W-1:0] wrap_axis(
      input logic signed [POS_W-1:0] a,
      input logic signed [POS_W-1:0] b,
      input logic [BOX_W-1:0]        len
   );
      logic signed [34:0] diff;
      logic signed [34:0] len_s;
      logic signed [34:0] d;
      diff  = 35'(b) - 35'(a);
      len_s = signed'({4'b0, len});
      if ((diff <<< 1) >= len_s) begin
         d = diff - len_s;
      end else if ((diff <<< 1) < -len_s) begin
         d = diff + len_s;
      end else begin
         d = diff;
      end
      if (d > 35'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (d < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return d[POS_W-1:0];
   endfunction

endpackage

// ===== rtl/hbf_sqrt.sv =====
module hbf_sqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [hbf_pkg::R2_W-1:0]   radicand,
   output logic [hbf_pkg::ROOT_W-1:0] root
);
   import hbf_pkg::*;

   logic [R2_W-1:0] rem_ff [SQRT_STAGES];
   logic [R2_W-1:0] res_ff [SQRT_STAGES];

   // One root bit per stage, bit weight fixed by stage position
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [R2_W-1:0] rem_prev;
      logic [R2_W-1:0] res_prev;
      logic [R2_W-1:0] bitv;
      logic [R2_W-1:0] trial;
      logic [R2_W-1:0] rem_in;
      logic [R2_W-1:0] res_in;

      if (k == 0) begin : g_first
         assign rem_prev = radicand;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      assign bitv  = R2_W'(1) << (R2_W - 2 - 2 * k);
      assign trial = res_prev + bitv;

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + bitv;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== rtl/hbf_div.sv =====
module hbf_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [hbf_pkg::QUO_W-1:0]  dividend,
   input  logic [hbf_pkg::ROOT_W-1:0] divisor,
   output logic [hbf_pkg::QUO_W-1:0]  quotient
);
   import hbf_pkg::*;

   logic [ROOT_W-1:0] rem_ff [DIV_STAGES];
   logic [ROOT_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0]  nq_ff  [DIV_STAGES];

   // Restoring division: shift in one dividend bit, produce one quotient bit
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [ROOT_W-1:0] rem_prev;
      logic [ROOT_W-1:0] den_prev;
      logic [QUO_W-1:0]  nq_prev;
      logic [ROOT_W:0]   trial;
      logic [ROOT_W:0]   diff;
      logic              ge;
      logic [ROOT_W-1:0] rem_in;
      logic [QUO_W-1:0]  nq_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign den_prev = divisor;
         assign nq_prev  = dividend;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
      end

      assign trial  = {rem_prev, nq_prev[QUO_W-1]};
      assign diff   = trial - {1'b0, den_prev};
      assign ge     = trial >= {1'b0, den_prev};
      assign rem_in = ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
      assign nq_in  = {nq_prev[QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            nq_ff[k]  <= nq_in;
         end
      end
   end

   assign quotient = nq_ff[DIV_STAGES-1];

endmodule

// ===== rtl/harmonic_bond_force.sv =====
// Throughput: one bond per cycle while the skid register is empty; the 32-stage square root
// and the 48-stage divider each retire one result bit per stage, and all stages advance together.
// A two-entry output (result register plus skid register) absorbs one stalled result;
// input is stalled only while the skid register is full.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
module harmonic_bond_force #(
   parameter int NUM_TYPES = hbf_pkg::NUM_TYPES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [hbf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hbf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_bond_type,
   input  logic signed [hbf_pkg::POS_W-1:0]      req_pos_a_x,
   input  logic signed [hbf_pkg::POS_W-1:0]      req_pos_a_y,
   input  logic signed [hbf_pkg::POS_W-1:0]      req_pos_a_z,
   input  logic signed [hbf_pkg::POS_W-1:0]      req_pos_b_x,
   input  logic signed [hbf_pkg::POS_W-1:0]      req_pos_b_y,
   input  logic signed [hbf_pkg::POS_W-1:0]      req_pos_b_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [hbf_pkg::OUT_W-1:0]      rsp_force_x,
   output logic signed [hbf_pkg::OUT_W-1:0]      rsp_force_y,
   output logic signed [hbf_pkg::OUT_W-1:0]      rsp_force_z,
   output logic signed [hbf_pkg::OUT_W-1:0]      rsp_energy_share,
   output logic                                  rsp_zero_length
);
   import hbf_pkg::*;

   localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int NST    = 3 + SQRT_STAGES + 1 + DIV_STAGES + 7;

   // ---------------- configuration registers ----------------
   logic [BOX_W-1:0]        box_ff [3];
   logic signed [POS_W-1:0] k_ff   [NUM_TYPES];
   logic signed [POS_W-1:0] r0_ff  [NUM_TYPES];

   // Write box lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff[0] <= BOX_RST;
         box_ff[1] <= BOX_RST;
         box_ff[2] <= BOX_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_X: box_ff[0] <= csr_wdata[BOX_W-1:0];
            CSR_BOX_Y: box_ff[1] <= csr_wdata[BOX_W-1:0];
            CSR_BOX_Z: box_ff[2] <= csr_wdata[BOX_W-1:0];
            default: ;
         endcase
      end
   end

   // Write stiffness and rest length of each type
   for (genvar t = 0; t < NUM_TYPES; t++) begin : g_type
      always_ff @(posedge clock) begin
         if (reset) begin
            k_ff[t]  <= K_RST;
            r0_ff[t] <= R0_RST;
         end else if (csr_we) begin
            if (csr_index == CSR_IDX_W'(CSR_TYPE_BASE + 2 * t)) begin
               k_ff[t] <= csr_wdata;
            end
            if (csr_index == CSR_IDX_W'(CSR_TYPE_BASE + 2 * t + 1)) begin
               r0_ff[t] <= csr_wdata;
            end
         end
      end
   end

   // ---------------- flow control ----------------
   logic [NST-1:0] vld_ff;
   logic           skid_vld_ff;
   logic           skid_vld_in;
   logic           adv;

   // Advance every stage unless the skid register is holding a result
   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // ---------------- stage 0: wrap and type select ----------------
   logic [TIDX_W-1:0] tsel_in;
   side_type          s0_in;
   side_type          s0_ff;

   assign tsel_in = (int'(req_bond_type) >= NUM_TYPES) ? TIDX_W'(NUM_TYPES - 1)
                                                       : TIDX_W'(req_bond_type);

   always_comb begin
      s0_in.dx   = wrap_axis(req_pos_a_x, req_pos_b_x, box_ff[0]);
      s0_in.dy   = wrap_axis(req_pos_a_y, req_pos_b_y, box_ff[1]);
      s0_in.dz   = wrap_axis(req_pos_a_z, req_pos_b_z, box_ff[2]);
      s0_in.k    = k_ff[tsel_in];
      s0_in.r0   = r0_ff[tsel_in];
      s0_in.dr   = '0;
      s0_in.zero = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
      end
   end

   // ---------------- stage 1: squares ----------------
   logic signed [63:0] sqx_in, sqy_in, sqz_in;
   logic [62:0]        sq_ff [3];
   side_type           s1_ff;

   assign sqx_in = s0_ff.dx * s0_ff.dx;
   assign sqy_in = s0_ff.dy * s0_ff.dy;
   assign sqz_in = s0_ff.dz * s0_ff.dz;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0] <= sqx_in[62:0];
         sq_ff[1] <= sqy_in[62:0];
         sq_ff[2] <= sqz_in[62:0];
         s1_ff    <= s0_ff;
      end
   end

   // ---------------- stage 2: squared length ----------------
   logic [R2_W-1:0] r2_in;
   logic [R2_W-1:0] r2_ff;
   side_type        s2_in;
   side_type        s2_ff;

   assign r2_in = R2_W'(sq_ff[0]) + R2_W'(sq_ff[1]) + R2_W'(sq_ff[2]);

   // Flag a zero-length bond
   always_comb begin
      s2_in      = s1_ff;
      s2_in.zero = (r2_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff <= r2_in;
         s2_ff <= s2_in;
      end
   end

   // ---------------- square root ----------------
   logic [ROOT_W-1:0] root;
   side_type          side_sq_ff [SQRT_STAGES];

   hbf_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (r2_ff),
      .root     (root)
   );

   // Carry bond data alongside the root stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_sq_ff[0] <= s2_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            side_sq_ff[i] <= side_sq_ff[i-1];
         end
      end
   end

   // ---------------- prep: dividend, divisor, r0 - r ----------------
   side_type          sp;
   side_type          s3_in;
   logic [QUO_W-1:0]  num_ff;
   logic [ROOT_W-1:0] den_ff;
   side_type          s3_ff;
   logic              neg_ff [DIV_STAGES + 1];

   assign sp = side_sq_ff[SQRT_STAGES-1];

   always_comb begin
      s3_in    = sp;
      s3_in.dr = 34'(sp.r0) - signed'({2'b0, root});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= {abs32(sp.r0), 16'b0};
         den_ff <= root;
         s3_ff  <= s3_in;
      end
   end

   // ---------------- divider ----------------
   logic [QUO_W-1:0] quo;
   side_type         side_dv_ff [DIV_STAGES];

   hbf_div u_div (
      .clock    (clock),
      .en       (adv),
      .dividend (num_ff),
      .divisor  (den_ff),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff[0]     <= sp.r0[POS_W-1];
         side_dv_ff[0] <= s3_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_dv_ff[i] <= side_dv_ff[i-1];
         end
         for (int i = 1; i <= DIV_STAGES; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // ---------------- stage M: scale minus one, squared deviation ----------------
   side_type           sd;
   logic signed [48:0] q_in;
   logic signed [48:0] m_in;
   logic signed [67:0] sdr_in;
   logic signed [48:0] m_ff;
   logic [66:0]        sdr_ff;
   side_type           s4_ff;

   assign sd     = side_dv_ff[DIV_STAGES-1];
   assign q_in   = neg_ff[DIV_STAGES] ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
   assign m_in   = q_in - 49'sd65536;
   assign sdr_in = sd.dr * sd.dr;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff   <= m_in;
         sdr_ff <= sdr_in[66:0];
         s4_ff  <= sd;
      end
   end

   // ---------------- stage P1: K*m partial products, clamp deviation square ----------------
   logic [47:0]      mabs_in;
   logic [63:0]      pk_lo_ff;
   logic [47:0]      pk_hi_ff;
   logic             tneg_ff;
   logic [MAG_W-1:0] smag_ff;
   side_type         s5_ff;

   assign mabs_in = m_ff[48] ? 48'(-m_ff) : 48'(m_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pk_lo_ff <= abs32(s4_ff.k) * mabs_in[31:0];
         pk_hi_ff <= abs32(s4_ff.k) * mabs_in[47:32];
         tneg_ff  <= s4_ff.k[POS_W-1] ^ m_ff[48];
         smag_ff  <= sat_mag(WIDE_W'(sdr_ff) >> 16);
         s5_ff    <= s4_ff;
      end
   end

   // ---------------- stage P2: sum K*m, K*s partial products ----------------
   logic [WIDE_W-1:0] tsum_ff;
   logic [63:0]       pe_lo_ff;
   logic [46:0]       pe_hi_ff;
   logic              tneg2_ff;
   side_type          s6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tsum_ff  <= WIDE_W'(pk_lo_ff) + (WIDE_W'(pk_hi_ff) << 32);
         pe_lo_ff <= abs32(s5_ff.k) * smag_ff[31:0];
         pe_hi_ff <= abs32(s5_ff.k) * smag_ff[46:32];
         tneg2_ff <= tneg_ff;
         s6_ff    <= s5_ff;
      end
   end

   // ---------------- stage P3: clamp t, sum K*s ----------------
   logic [MAG_W-1:0]  tmag_ff;
   logic [WIDE_W-1:0] esum_ff;
   logic              tneg3_ff;
   side_type          s7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tmag_ff  <= sat_mag(tsum_ff >> 16);
         esum_ff  <= WIDE_W'(pe_lo_ff) + (WIDE_W'(pe_hi_ff) << 32);
         tneg3_ff <= tneg2_ff;
         s7_ff    <= s6_ff;
      end
   end

   // ---------------- stage P4: force partial products, energy ----------------
   logic signed [POS_W-1:0] dax [3];
   logic [MAG_W-1:0]        emag_in;
   logic [63:0]             pf_lo_ff [3];
   logic [46:0]             pf_hi_ff [3];
   logic                    fneg_ff  [3];
   logic signed [OUT_W-1:0] energy_ff;
   logic                    zero4_ff;

   assign dax[0]  = s7_ff.dx;
   assign dax[1]  = s7_ff.dy;
   assign dax[2]  = s7_ff.dz;
   // A K*s product that does not fit in 64 bits saturates before the shift
   assign emag_in = (|esum_ff[WIDE_W-1:64]) ? MAG_MAX : sat_mag(esum_ff >> 18);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pf_lo_ff[i] <= abs32(dax[i]) * tmag_ff[31:0];
            pf_hi_ff[i] <= abs32(dax[i]) * tmag_ff[46:32];
            fneg_ff[i]  <= tneg3_ff ^ dax[i][POS_W-1];
         end
         energy_ff <= s7_ff.k[POS_W-1] ? -signed'({1'b0, emag_in})
                                        : signed'({1'b0, emag_in});
         zero4_ff  <= s7_ff.zero;
      end
   end

   // ---------------- stage P5: sum force products ----------------
   logic [WIDE_W-1:0]       fsum_ff [3];
   logic                    fneg5_ff [3];
   logic signed [OUT_W-1:0] energy5_ff;
   logic                    zero5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            fsum_ff[i]  <= WIDE_W'(pf_lo_ff[i]) + (WIDE_W'(pf_hi_ff[i]) << 32);
            fneg5_ff[i] <= fneg_ff[i];
         end
         energy5_ff <= energy_ff;
         zero5_ff   <= zero4_ff;
      end
   end

   // ---------------- result register: clamp, sign, zero-length override ----------------
   logic [MAG_W-1:0]        fmag_in [3];
   logic signed [OUT_W-1:0] force_ff [3];
   logic signed [OUT_W-1:0] energy_out_ff;
   logic                    zero_out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fmag_in[i] = sat_mag(fsum_ff[i] >> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (zero5_ff) begin
               force_ff[i] <= '0;
            end else begin
               force_ff[i] <= fneg5_ff[i] ? -signed'({1'b0, fmag_in[i]})
                                          : signed'({1'b0, fmag_in[i]});
            end
         end
         energy_out_ff <= zero5_ff ? '0 : energy5_ff;
         zero_out_ff   <= zero5_ff;
      end
   end

   // ---------------- skid register ----------------
   logic signed [OUT_W-1:0] skid_force_ff [3];
   logic signed [OUT_W-1:0] skid_energy_ff;
   logic                    skid_zero_ff;

   // Hold a stalled result; every stage waits while it is held
   always_comb begin
      if (skid_vld_ff) begin
         skid_vld_in = rsp_stall;
      end else begin
         skid_vld_in = vld_ff[NST-1] && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_force_ff  <= force_ff;
         skid_energy_ff <= energy_out_ff;
         skid_zero_ff   <= zero_out_ff;
      end
   end

   // Present the skid entry first, else the result register
   assign rsp_valid        = skid_vld_ff || vld_ff[NST-1];
   assign rsp_force_x      = skid_vld_ff ? skid_force_ff[0] : force_ff[0];
   assign rsp_force_y      = skid_vld_ff ? skid_force_ff[1] : force_ff[1];
   assign rsp_force_z      = skid_vld_ff ? skid_force_ff[2] : force_ff[2];
   assign rsp_energy_share = skid_vld_ff ? skid_energy_ff : energy_out_ff;
   assign rsp_zero_length  = skid_vld_ff ? skid_zero_ff : zero_out_ff;

   // ---------------- assertions ----------------
   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_length) |->
         (rsp_force_x == '0 && rsp_force_y == '0 && rsp_force_z == '0 &&
          rsp_energy_share == '0))
      else $error("zero-length result carries nonzero outputs");

   a_no_most_negative: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_force_x != {1'b1, {(OUT_W-1){1'b0}}} &&
          rsp_force_y != {1'b1, {(OUT_W-1){1'b0}}} &&
          rsp_force_z != {1'b1, {(OUT_W-1){1'b0}}} &&
          rsp_energy_share != {1'b1, {(OUT_W-1){1'b0}}}))
      else $error("saturation produced the most negative value");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(vld_ff[NST-1] && rsp_stall))
      else $error("skid register filled without a stalled result");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      ($past(skid_vld_ff) && !$past(reset)) |-> $stable(vld_ff))
      else $error("pipeline moved while the skid register was full");

endmodule
